@@ src/rfw_pkg.sv @@
// Shared types, constants and helpers for the RGB fade WS2812 encoder.
// No dependencies; imported by every module of the block.
package rfw_pkg;

	localparam int RAND_W     = 15;
	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 24;
	localparam int TICK_W     = 14;
	localparam int QV_W       = 16;
	localparam int DIVIDEND_W = 16;
	localparam int DIVISOR_W  = 14;
	localparam int WORD_W     = 32;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;
	localparam int BRI_W      = 8;
	localparam int SCALE_W    = 16;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_FADE_SECONDS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRI_SCALE    = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INVERT_LINE  = 8'd3;

	// Color channel codes carried in tuser
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	// Line codes for one color bit
	localparam logic [3:0] CODE_ZERO_NORMAL = 4'h8;
	localparam logic [3:0] CODE_ONE_NORMAL  = 4'hE;
	localparam logic [3:0] CODE_ZERO_INVERT = 4'h7;
	localparam logic [3:0] CODE_ONE_INVERT  = 4'h1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_START = 6'b000010,
		ST_DIV   = 6'b000100,
		ST_MUL1  = 6'b001000,
		ST_MUL2  = 6'b010000,
		ST_MUL3  = 6'b100000
	} fsm_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

	// Expand one color byte into eight 4-bit line codes, LSB first, halves swapped
	function automatic logic [WORD_W-1:0] encode_byte(input logic [CHAN_W-1:0] v,
	                                                  input logic invert);
		logic [WORD_W-1:0] w;
		logic [3:0]        c0;
		logic [3:0]        c1;
		c0 = invert ? CODE_ZERO_INVERT : CODE_ZERO_NORMAL;
		c1 = invert ? CODE_ONE_INVERT : CODE_ONE_NORMAL;
		w  = '0;
		for (int i = 0; i < CHAN_W; i++) begin
			w[4*i +: 4] = v[i] ? c1 : c0;
		end
		return {w[15:0], w[31:16]};
	endfunction

endpackage

@@ src/rfw_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
// Depends on rfw_pkg for widths and the request/response structs.
module rfw_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rfw_pkg::div_req_t req,
	output rfw_pkg::div_rsp_t rsp
);
	import rfw_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [DIVISOR_W:0]    trial;
	logic                  fits;

	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			// shift the next dividend bit in, subtract when it fits
			rem_q <= fits ? DIVISOR_W'(trial - {1'b0, dsr_q}) : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

@@ src/rgb_fade_ws2812_encoder.sv @@
// Sequence: an accepted tick yields its red word, then green and blue, each channel
// passing through start, 16 divider steps, divider done and three multiply stages;
// a channel with no fade skips the divider.
// Ticks are paced by the shared divider, used once per fading channel; no new tick is
// taken before the last one is through. The input is held off while a tick is in work;
// the blue word may still wait.
// Reset (arst_n low, asynchronous): counter and colors clear, registers take defaults.
module rgb_fade_ws2812_encoder (
	input  logic                            clk,
	input  logic                            arst_n,
	// input stream: tdata[14:0] random_value, [15] zero
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [15:0]                     s_tdata,
	// output stream: tdata[31:0] i2s_word
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [rfw_pkg::WORD_W-1:0]      m_tdata,
	// tuser[1:0] color_index
	output logic [1:0]                      m_tuser,
	output logic                            m_tlast,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rfw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [rfw_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rfw_pkg::*;

	// configuration registers
	logic [7:0]         fade_q;
	logic [BRI_W-1:0]   bri_q;
	logic [SCALE_W-1:0] scale_q;
	logic               inv_q;

	// fade state
	logic [TICK_W-1:0]  tick_q;
	logic [COLOR_W-1:0] old_q;
	logic [COLOR_W-1:0] tgt_q;

	// sequencer and per-channel datapath
	fsm_t               state_q;
	logic [1:0]         ch_q;
	logic [CHAN_W-1:0]  from_q;
	logic               up_q;
	logic [QV_W-1:0]    step_q;
	logic [QV_W-1:0]    qv_q;
	logic [QV_W+BRI_W-1:0] pb_q;

	// output register
	logic               m_valid_q;
	logic [WORD_W-1:0]  m_data_q;
	logic [1:0]         m_user_q;
	logic               m_last_q;

	logic [TICK_W-1:0]  period;
	logic [TICK_W-1:0]  tick_inc;
	logic               reload;
	logic [COLOR_W-1:0] new_color;
	logic [RAND_W:0]    rv2;
	logic [4:0]         r5;
	logic [5:0]         g6;
	logic [4:0]         b5;
	logic [CHAN_W-1:0]  ch_from;
	logic [CHAN_W-1:0]  ch_to;
	logic [CHAN_W-1:0]  diff;
	logic [29:0]        step_prod;
	logic [QV_W-1:0]    from_q88;
	logic [39:0]        ps_prod;
	logic               out_free;
	logic               s_fire;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_fire    = s_tvalid && s_tready;
	assign out_free  = !m_valid_q || m_tready;

	// period = fade_seconds * 50, built from shifts
	assign period   = TICK_W'({6'd0, fade_q} << 5) + TICK_W'({6'd0, fade_q} << 4)
	                + TICK_W'({6'd0, fade_q} << 1);
	assign tick_inc = tick_q + 1'b1;
	assign reload   = tick_inc >= period;

	// new target: doubled random value read as RGB565, bits replicated up to 8
	assign rv2       = {s_tdata[RAND_W-1:0], 1'b0};
	assign r5        = rv2[15:11];
	assign g6        = rv2[10:5];
	assign b5        = rv2[4:0];
	assign new_color = {r5, r5[4:2], g6, g6[5:4], b5, b5[4:2]};

	always_comb begin
		case (ch_q)
			CH_RED: begin
				ch_from = old_q[23:16];
				ch_to   = tgt_q[23:16];
			end
			CH_GREEN: begin
				ch_from = old_q[15:8];
				ch_to   = tgt_q[15:8];
			end
			default: begin
				ch_from = old_q[7:0];
				ch_to   = tgt_q[7:0];
			end
		endcase
	end

	assign diff = (ch_from < ch_to) ? ch_to - ch_from : ch_from - ch_to;

	assign div_req.start    = (state_q == ST_START) && (period != '0) && (ch_from != ch_to);
	assign div_req.dividend = {diff, 8'd0};
	assign div_req.divisor  = period;

	rfw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign step_prod = step_q * tick_q;
	assign from_q88  = {from_q, 8'd0};
	assign ps_prod   = pb_q * scale_q;

	// configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q  <= 8'd4;
			bri_q   <= 8'd255;
			scale_q <= 16'd257;
			inv_q   <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FADE_SECONDS: fade_q  <= cfg_data[7:0];
				REG_BRIGHTNESS:   bri_q   <= cfg_data[BRI_W-1:0];
				REG_BRI_SCALE:    scale_q <= cfg_data[SCALE_W-1:0];
				REG_INVERT_LINE:  inv_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer: tick update, then per channel divide (fading channels only), interpolate, scale, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ch_q      <= CH_RED;
			tick_q    <= '0;
			old_q     <= '0;
			tgt_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// load a new word or drop the one just taken
			if (state_q == ST_MUL3 && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_fire) begin
						ch_q    <= CH_RED;
						state_q <= ST_START;
						if (reload) begin
							tick_q <= '0;
							old_q  <= tgt_q;
							tgt_q  <= new_color;
						end else begin
							tick_q <= tick_inc;
						end
					end
				end
				ST_START: begin
					state_q <= div_req.start ? ST_DIV : ST_MUL1;
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_MUL1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_MUL3;
				ST_MUL3: begin
					// hold the byte until the output register frees up
					if (out_free) begin
						if (ch_q == CH_BLUE) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + 1'b1;
							state_q <= ST_START;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_START) begin
			up_q <= ch_from < ch_to;
			if (div_req.start) begin
				from_q <= ch_from;
			end else begin
				// no fade: start from the target with a zero step
				from_q <= ch_to;
				step_q <= '0;
			end
		end
		if (state_q == ST_DIV && div_rsp.done) begin
			step_q <= div_rsp.quotient;
		end
		if (state_q == ST_MUL1) begin
			qv_q <= up_q ? from_q88 + step_prod[QV_W-1:0] : from_q88 - step_prod[QV_W-1:0];
		end
		if (state_q == ST_MUL2) begin
			pb_q <= qv_q * bri_q;
		end
		if (state_q == ST_MUL3 && out_free) begin
			m_data_q <= encode_byte(
				(ps_prod[39:32] != 8'd0) ? 8'hFF : ps_prod[31:24], inv_q);
			m_user_q <= ch_q;
			m_last_q <= ch_q == CH_BLUE;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

endmodule

@@ src/rfw_checker.sv @@
// Port-level assertions for the RGB fade WS2812 encoder, bound to the top level.
// Depends on rfw_pkg for the color channel codes.
module rfw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import rfw_pkg::*;

	// last marks the blue word and nothing else
	a_last_blue: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tuser == CH_BLUE)))
		else $error("tlast does not match blue channel");

	// only three channel codes exist
	a_chan_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == CH_RED || m_tuser == CH_GREEN || m_tuser == CH_BLUE))
		else $error("bad channel code");

	// a new tick waits until the first two words of the previous one are out
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != CH_BLUE) |-> !s_tready)
		else $error("input ready while a tick is in work");

	// the input is not ready again in the cycle after a tick is accepted
	a_one_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after a tick");

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output word changed");

endmodule

bind rgb_fade_ws2812_encoder rfw_checker u_rfw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
